[rtl/core/modular_inverse_ext_euclid_top_macros.svh]
// Assertion macros shared by the modular inverse RTL.
`ifndef MODULAR_INVERSE_EXT_EUCLID_TOP_MACROS_SVH
`define MODULAR_INVERSE_EXT_EUCLID_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MIE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MIE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mie_pkg.sv]
// Shared constants and types of the modular inverse block.
package mie_pkg;

  localparam int WIDTH  = 32;
  localparam int DATA_W = ((WIDTH + 7) / 8) * 8;
  localparam int CNT_W  = $clog2(WIDTH);

  localparam logic [WIDTH-1:0] RESET_MODULUS = WIDTH'(64'd1000000007);

  typedef logic [WIDTH-1:0] word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[rtl/core/mie_div.sv]
// Bit-serial restoring divider that also forms quotient times a multiplier.
module mie_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  mie_pkg::word_t      dividend,
  input  mie_pkg::word_t      divisor,
  input  mie_pkg::word_t      mult,
  output mie_pkg::word_t      rem,
  output mie_pkg::word_t      prod,
  output mie_pkg::div_status_t status
);
  import mie_pkg::*;

  word_t            num;
  word_t            den;
  word_t            mul;
  word_t            rem_r;
  word_t            acc;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [WIDTH:0]   rem_sh;
  word_t            rem_sub;
  logic             ge;
  word_t            rem_next;
  word_t            acc_next;

  // One quotient bit per cycle, MSB first; Horner form keeps q*mult in step.
  always_comb begin
    rem_sh   = {rem_r, num[WIDTH-1]};
    rem_sub  = rem_sh[WIDTH-1:0] - den;
    ge       = (rem_sh >= {1'b0, den});
    rem_next = ge ? rem_sub : rem_sh[WIDTH-1:0];
    acc_next = {acc[WIDTH-2:0], 1'b0} + (ge ? mul : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num   <= dividend;
      den   <= divisor;
      mul   <= mult;
      rem_r <= '0;
      acc   <= '0;
      cnt   <= CNT_W'(WIDTH - 1);
    end else if (busy) begin
      num   <= {num[WIDTH-2:0], 1'b0};
      rem_r <= rem_next;
      acc   <= acc_next;
      cnt   <= cnt - 1'b1;
    end
  end

  assign rem         = rem_r;
  assign prod        = acc;
  assign status.busy = busy;
  assign status.done = done;

endmodule

[rtl/core/modular_inverse_ext_euclid_top.sv]
// Top level of the modular inverse block: sequencer, coefficient registers, output beat.
//
// Usage:
//   Input channel s_*: one beat carries a value a in s_tdata. Output channel m_*:
//   one beat per input, m_tdata holds the inverse of a modulo the configured
//   modulus (0..modulus-1), m_tuser[0] is set when gcd(a, modulus) is 1; when it
//   is not, the inverse reads 0. Write the modulus through cfg_we/cfg_wdata only
//   while no beat is in flight; it resets to 1000000007.
// Throughput:
//   One item at a time; s_tready is high only while the sequencer is idle.
//   Each Euclid remainder step is one pass of the shared bit-serial divider:
//   one quotient bit per cycle plus launch and writeback. An item with k
//   nonzero remainders (k up to about 46 for 32-bit operands) takes k + 1 passes.
// Reset: rst is synchronous; it idles the sequencer and drops m_tvalid.
// Stall: a finished result sits in the output register; the block takes the
//   next input while it waits and holds its own next result until m_tready.
module modular_inverse_ext_euclid_top (
  input  logic                       clk,
  input  logic                       rst,
  // s_tdata fields, low bit up: value
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [mie_pkg::DATA_W-1:0] s_tdata,
  // m_tdata fields, low bit up: inverse
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [mie_pkg::DATA_W-1:0] m_tdata,
  // m_tuser fields, low bit up: coprime
  output logic [0:0]                 m_tuser,
  input  logic                       cfg_we,
  input  logic [mie_pkg::WIDTH-1:0]  cfg_wdata
);
  import mie_pkg::*;

  `include "modular_inverse_ext_euclid_top_macros.svh"

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LAUNCH = 3'd1;
  localparam logic [2:0] ST_WAIT   = 3'd2;
  localparam logic [2:0] ST_RED    = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  logic [2:0]  state;
  word_t       modulus;

  // Euclid operands and the Bezout coefficient of the value, as sign+magnitude
  word_t       a_r;
  word_t       b_r;
  word_t       mag0;
  word_t       mag1;
  word_t       mag;
  logic        neg0;
  logic        neg1;
  logic        neg;

  word_t       inv_r;
  logic        cop_r;
  logic        out_valid;

  word_t       div_rem;
  word_t       div_prod;
  div_status_t div_st;
  logic        div_start;

  word_t       nmag;
  logic        in_beat;
  logic        out_beat;
  logic        load_out;
  logic        coprime_fin;
  word_t       inv_fin;

  assign in_beat   = s_tvalid && s_tready;
  assign out_beat  = m_tvalid && m_tready;
  assign s_tready  = (state == ST_IDLE);
  assign div_start = (state == ST_LAUNCH);
  assign load_out  = (state == ST_FIN) && (!out_valid || m_tready);

  // x_next = x0 - q*x1 with opposite signs: magnitudes add
  assign nmag = mag0 + div_prod;

  always_comb begin
    coprime_fin = (b_r == word_t'(1));
    inv_fin     = '0;
    if (coprime_fin) begin
      inv_fin = (neg && mag != '0) ? (modulus - mag) : mag;
    end
  end

  mie_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (a_r),
    .divisor  (b_r),
    .mult     (mag1),
    .rem      (div_rem),
    .prod     (div_prod),
    .status   (div_st)
  );

  // Modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= RESET_MODULUS;
    end else if (cfg_we) begin
      modulus <= cfg_wdata;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            // zero modulus: skip division, falls out as not coprime
            state <= (modulus == '0) ? ST_RED : ST_LAUNCH;
          end
        end
        ST_LAUNCH: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_st.done) begin
            state <= (div_rem != '0) ? ST_LAUNCH : ST_RED;
          end
        end
        ST_RED: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Operand and coefficient datapath
  always_ff @(posedge clk) begin
    if (in_beat) begin
      a_r  <= s_tdata[WIDTH-1:0];
      b_r  <= modulus;
      mag0 <= word_t'(1);
      mag1 <= '0;
      mag  <= '0;
      neg0 <= 1'b0;
      neg1 <= 1'b1;
      neg  <= 1'b0;
    end else if (state == ST_WAIT && div_st.done && div_rem != '0) begin
      // advance the remainder sequence by one step
      a_r  <= b_r;
      b_r  <= div_rem;
      mag0 <= mag1;
      neg0 <= neg1;
      mag1 <= nmag;
      neg1 <= neg0;
      mag  <= nmag;
      neg  <= neg0;
    end else if (state == ST_RED && mag >= modulus) begin
      // fold the magnitude into 0..modulus-1
      mag <= mag - modulus;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_beat) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      inv_r <= inv_fin;
      cop_r <= coprime_fin;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = DATA_W'(inv_r);
  assign m_tuser[0] = cop_r;

  `MIE_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_beat, !s_tready,
    "input taken while a previous item is still in work")
  `MIE_ASSERT_NOW(a_done_in_wait, clk, rst, div_st.done, state == ST_WAIT,
    "divider finished outside its wait state")
  `MIE_ASSERT_NOW(a_result_range, clk, rst, m_tvalid,
    cop_r ? (inv_r < modulus || modulus == word_t'(1)) : (inv_r == '0),
    "result out of range for its coprime flag")
  `MIE_ASSERT_NOW(a_no_start_busy, clk, rst, div_start, !div_st.busy,
    "divider launched while busy")

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the modular inverse block: streams values, predicts each result.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mie_pkg::*;

  // Receiver hold-off length, the watchdog limit on quiet cycles, and the drain wait
  // at the end.
  localparam int HOLD_CYCLES = 3000;
  localparam int QUIET_LIMIT = 20000;
  localparam int DRAIN_WAIT  = 2000;

  typedef struct packed {
    word_t inverse;
    logic  coprime;
  } inv_result_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [DATA_W-1:0]   s_tdata   = '0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [DATA_W-1:0]   m_tdata;
  logic [0:0]          m_tuser;
  logic                cfg_we    = 1'b0;
  logic [WIDTH-1:0]    cfg_wdata = '0;

  word_t       pending_values[$];   // values waiting to be offered on the input
  inv_result_t expected_inverses[$];
  word_t       modulus_shadow = RESET_MODULUS;
  logic        value_taken    = 1'b0;
  logic        steady         = 1'b0;   // no random idling on either side
  int          holds_asked    = 0;
  int          holds_served   = 0;
  int          hold_left      = 0;
  int          quiet_cycles   = 0;
  int          mismatch_count = 0;

  modular_inverse_ext_euclid_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Extended Euclid on (value, m) with the coefficient of value kept as a
  // magnitude and a sign; the signs alternate, so each new magnitude is a sum.
  function automatic inv_result_t mod_inverse(word_t value, word_t m);
    logic [2*WIDTH-1:0] dividend, divisor, rem, quo;
    logic [2*WIDTH-1:0] mag_prev, mag_cur, mag_next, red;
    logic               neg_prev, neg_cur, neg_next;
    inv_result_t        res;
    res      = '0;
    mag_prev = 1;
    neg_prev = 1'b0;
    mag_cur  = 0;
    neg_cur  = 1'b1;
    if (m != 0) begin
      divisor = m;
      rem     = value % m;
      quo     = value / m;
      while (rem != 0) begin
        mag_next = mag_prev + quo * mag_cur;
        neg_next = neg_prev;
        mag_prev = mag_cur;
        neg_prev = neg_cur;
        mag_cur  = mag_next;
        neg_cur  = neg_next;
        dividend = divisor;
        divisor  = rem;
        rem      = dividend % divisor;
        quo      = dividend / divisor;
      end
      // With no remainder step at all the magnitude is zero, so the sign is moot.
      if (divisor == 1) begin
        red         = mag_cur % m;
        res.coprime = 1'b1;
        res.inverse = (neg_cur && red != 0) ? word_t'(m - red) : word_t'(red);
      end
    end
    return res;
  endfunction

  // Input driver: hold an offered beat until taken, otherwise offer the next
  // value or idle at random.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (value_taken) void'(pending_values.pop_front());
      if (s_tvalid && !value_taken) begin
        // hold the current beat
      end else if (pending_values.size() != 0 && (steady || $urandom_range(99) >= 27)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'(pending_values[0]);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output ready: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (holds_served < holds_asked) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES;
      m_tready     <= 1'b0;
    end else begin
      m_tready <= steady || $urandom_range(99) >= 27;
    end
  end

  // Monitor: predict on each input beat, check each output beat.
  always @(posedge clk) begin
    inv_result_t want;
    value_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready)
      expected_inverses.push_back(mod_inverse(word_t'(s_tdata), modulus_shadow));
    if (!rst && m_tvalid && m_tready) begin
      if (expected_inverses.size() == 0) begin
        $display("%0t: result beat with none expected: inverse=%0d coprime=%0d",
                 $time, m_tdata[WIDTH-1:0], m_tuser[0]);
        mismatch_count++;
      end else begin
        want = expected_inverses.pop_front();
        if (m_tdata[WIDTH-1:0] !== want.inverse) begin
          $display("%0t: inverse mismatch: expected %0d, actual %0d",
                   $time, want.inverse, m_tdata[WIDTH-1:0]);
          mismatch_count++;
        end
        if (m_tuser[0] !== want.coprime) begin
          $display("%0t: coprime mismatch: expected %0d, actual %0d",
                   $time, want.coprime, m_tuser[0]);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_values.size() != 0 || expected_inverses.size() != 0) @(posedge clk);
  endtask

  // Write the modulus once every result is back, then resume on a rising edge.
  task automatic load_modulus(word_t m);
    wait_drained();
    @(negedge clk);
    cfg_we         <= 1'b1;
    cfg_wdata      <= m;
    modulus_shadow  = m;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    word_t m;
    word_t v;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset modulus, zero, one, values at and around the modulus, extremes.
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd1);
    pending_values.push_back(32'd2);
    pending_values.push_back(RESET_MODULUS - 1);
    pending_values.push_back(RESET_MODULUS);
    pending_values.push_back(RESET_MODULUS + 1);
    pending_values.push_back(32'hFFFF_FFFF);
    pending_values.push_back(32'h8000_0000);

    // Smallest regular modulus.
    load_modulus(32'd2);
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd1);
    pending_values.push_back(32'hFFFF_FFFF);

    // Consecutive Fibonacci numbers: the longest remainder chain at this width.
    load_modulus(32'd2971215073);
    pending_values.push_back(32'd1836311903);
    pending_values.push_back(32'd0);

    // Largest modulus; 3 shares a factor with it.
    load_modulus(32'hFFFF_FFFF);
    pending_values.push_back(32'd3);
    pending_values.push_back(32'hFFFF_FFFE);
    pending_values.push_back(32'h5555_5555);

    // Modulus one: always coprime, inverse zero.
    load_modulus(32'd1);
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd7);

    // Modulus zero: no division, never coprime.
    load_modulus(32'd0);
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd5);

    // Random phases, each under its own modulus.
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0, 5:    m = $urandom | 32'h8000_0000;
        1:       m = 32'hFFFF_FFFB;
        2:       m = $urandom_range(255, 2);
        3:       m = 32'h1 << $urandom_range(31, 1);
        4:       m = $urandom_range(65535, 2);
        6:       m = RESET_MODULUS;
        7:       m = 32'hFFFF_FFFF;
        8:       m = 32'd2;
        default: m = $urandom_range(32'hFFFF_FFFF, 2);
      endcase
      load_modulus(m);
      steady = (phase == 4);
      // Let the block back up behind a long output stall.
      if (phase == 2) holds_asked++;
      for (int i = 0; i < 130; i++) begin
        case ($urandom_range(9))
          6:       v = $urandom_range(16);
          7:       v = m * $urandom_range(7);
          8:       v = m + $urandom_range(4) - 2;
          9:       v = $urandom * ((m % 3 == 0) ? 3 : 2);
          default: v = $urandom;
        endcase
        pending_values.push_back(v);
      end
    end

    wait_drained();
    steady = 1'b0;
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
